>>> rtl/ssm_pkg.sv
// Package for the sorted set membership merge block.
// Holds the set depth, derived widths, action and state codes, and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package ssm_pkg;

  localparam int SET_DEPTH = 4096;
  localparam int ADDR_W    = $clog2(SET_DEPTH);
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int VAL_W     = 32;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_PROBE  = 2'd2
  } action_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_CMP  = 1'b1
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic clear;
    logic append;
    logic probe_start;
    logic skip;
    logic emit;
  } ssm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic present;
    logic in_range;
    logic less;
    logic out_free;
  } ssm_sts_t;

endpackage

>>> rtl/ssm_if.sv
// Handshake channels of the sorted set membership merge block.
// Depends on ssm_pkg for the value width.
`timescale 1ns / 1ps

interface ssm_in_if;
  import ssm_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [VAL_W-1:0] item_value;
  logic               item_present;

  modport source (output valid, output action, output item_value, output item_present,
                  input ready);
  modport sink   (input valid, input action, input item_value, input item_present,
                  output ready);
endinterface

interface ssm_out_if;
  logic valid;
  logic ready;
  logic found;
  logic set_overflowed;

  modport source (output valid, output found, output set_overflowed, input ready);
  modport sink   (input valid, input found, input set_overflowed, output ready);
endinterface

>>> rtl/ssm_datapath.sv
// Datapath: set memory, fill count, probe cursor, overflow flag,
// compare logic and output register. Depends on ssm_pkg.
`timescale 1ns / 1ps

module ssm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssm_pkg::ssm_cmd_t             cmd_i,
  output ssm_pkg::ssm_sts_t             sts_o,
  input  logic signed [ssm_pkg::VAL_W-1:0] item_value_i,
  input  logic                          item_present_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          found_o,
  output logic                          set_overflowed_o
);
  import ssm_pkg::*;

  logic signed [VAL_W-1:0] mem [SET_DEPTH];

  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        cursor_q, cursor_d;
  logic                    ovf_q, ovf_d;
  logic signed [VAL_W-1:0] probe_q;
  logic                    present_q;
  logic signed [VAL_W-1:0] rdata_q;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    full;
  logic                    hit;
  logic                    out_valid_q;
  logic                    found_q;
  logic                    ovf_out_q;

  assign full = (count_q == CNT_W'(SET_DEPTH));

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    ovf_d    = ovf_q;
    if (cmd_i.clear) begin
      count_d  = '0;
      cursor_d = '0;
      ovf_d    = 1'b0;
    end else if (cmd_i.append) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else if (cmd_i.skip) begin
      cursor_d = cursor_q + CNT_W'(1);
    end
  end

  // The read follows the cursor: its current value on a new probe, the next one on a skip.
  // A cursor at the end wraps the address; that read is never used.
  assign rd_en   = cmd_i.probe_start | cmd_i.skip;
  assign rd_addr = cursor_d[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      mem[count_q[ADDR_W-1:0]] <= item_value_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
    if (cmd_i.probe_start) begin
      probe_q   <= item_value_i;
      present_q <= item_present_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
      ovf_q    <= 1'b0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
      ovf_q    <= ovf_d;
    end
  end

  assign sts_o.present  = present_q;
  assign sts_o.in_range = (cursor_q < count_q);
  assign sts_o.less     = (rdata_q < probe_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign hit = present_q && sts_o.in_range && (rdata_q == probe_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      found_q   <= hit;
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = found_q;
  assign set_overflowed_o = ovf_out_q;

  a_cursor_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q)
    else $error("probe cursor moved past the set count");

  a_count_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(SET_DEPTH))
    else $error("set count exceeds the set depth");

  a_ovf_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(count_q) == CNT_W'(SET_DEPTH))
    else $error("overflow flag set while the set had room");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> sts_o.out_free)
    else $error("result loaded over an untaken result");

endmodule

>>> rtl/ssm_ctrl.sv
// Controller state machine: takes items, steps the cursor over smaller set
// values and loads the result. Depends on ssm_pkg.
`timescale 1ns / 1ps

module ssm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        action_i,
  output logic              in_ready_o,
  input  ssm_pkg::ssm_sts_t sts_i,
  output ssm_pkg::ssm_cmd_t cmd_o
);
  import ssm_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_CLEAR:  cmd_o.clear  = 1'b1;
            ACT_APPEND: cmd_o.append = 1'b1;
            ACT_PROBE: begin
              cmd_o.probe_start = 1'b1;
              state_d           = ST_CMP;
            end
            default: ;
          endcase
        end
      end
      ST_CMP: begin
        // Read data holds the value under the cursor.
        if (sts_i.present && sts_i.in_range && sts_i.less) begin
          cmd_o.skip = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/sorted_set_membership_merge.sv
// Top level of the sorted set membership merge block.
// Joins ssm_ctrl and ssm_datapath; depends on ssm_pkg and the ssm interfaces.
// Items are taken only while no probe is running. A probe steps the cursor over
// each stored value below it, with one read per step from the single read port
// of the set memory; its result is loaded into the output register when that is free.
// Reset clears the set count, cursor, overflow flag and output valid flag; the store is not cleared.
`timescale 1ns / 1ps

module sorted_set_membership_merge (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssm_in_if.sink    in_i,
  ssm_out_if.source out_o
);
  import ssm_pkg::*;

  ssm_cmd_t cmd;
  ssm_sts_t sts;

  ssm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .action_i   (in_i.action),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssm_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .item_value_i     (in_i.item_value),
    .item_present_i   (in_i.item_present),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .found_o          (out_o.found),
    .set_overflowed_o (out_o.set_overflowed)
  );

endmodule
